>>> hdl/drc_pkg.sv
// Shared types for the dirty rectangle coalescer: controller commands and datapath status.
`default_nettype none
package drc_pkg;

   typedef enum logic [1:0] {
      WSEL_SUBJ  = 2'd0,
      WSEL_MERGE = 2'd1,
      WSEL_RUN   = 2'd2,
      WSEL_M0    = 2'd3
   } wsel_type;

   typedef struct packed {
      logic     load_req;
      logic     load_ram_subj;
      logic     calc_sarea;
      logic     load_entry;
      logic     calc_areas;
      logic     run_update;
      logic     save_m0;
      logic     ram_we;
      wsel_type wsel;
      logic     rsp_load;
      logic     rsp_last;
      logic     rsp_empty;
   } cmd_type;

   typedef struct packed {
      logic entry_holds_subj;
      logic subj_holds_entry;
      logic merge_ok;
      logic run_ok;
   } status_type;

endpackage
`default_nettype wire

>>> hdl/dirty_rect_coalescer_top.sv
// Top level of the dirty rectangle coalescer: controller plus datapath.
//
// Use: send transactions on the req_ channel. req_action = 0 adds the
// rectangle (req_rect_x/y/w/h) to the store and gives no result;
// req_action = 1 drains the store and returns the surviving rectangles on
// the rsp_ channel, the final one marked by rsp_last_rect. Draining an
// empty store returns one transaction with rsp_store_empty and
// rsp_last_rect set and zero coordinates.
// Sequence: an add loads the rectangle and its area, then walks the stored
// entries in turn (read, load with cover, area multiply, decide). A drain
// pops an entry (pop, take, area), compares it against the remaining
// entries in the same steps and emits it as one transaction unless it
// was dropped or merged; an empty drain goes straight to its response.
// The store is single-port and is walked one entry at a time; one
// transaction is worked at a time and req_stall stays high meanwhile.
// Reset clears the entry count and the result valid; the store contents
// need no clearing since only counted entries are read.
// A stall on rsp_ holds the result register; the drain waits until it
// frees before loading the next result.
`default_nettype none
module dirty_rect_coalescer_top #(
   parameter int MAX_REGIONS = 16,
   parameter int COORD_BITS  = 12
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_action,
   input  wire logic [COORD_BITS-1:0] req_rect_x,
   input  wire logic [COORD_BITS-1:0] req_rect_y,
   input  wire logic [COORD_BITS:0]   req_rect_w,
   input  wire logic [COORD_BITS:0]   req_rect_h,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [COORD_BITS-1:0] rsp_out_x,
   output logic      [COORD_BITS-1:0] rsp_out_y,
   output logic      [COORD_BITS:0]   rsp_out_w,
   output logic      [COORD_BITS:0]   rsp_out_h,
   output logic                       rsp_last_rect,
   output logic                       rsp_store_empty
);

   drc_pkg::cmd_type                 cmd;
   drc_pkg::status_type              status;
   logic [$clog2(MAX_REGIONS)-1:0]   ram_addr;

   // sequencing: counts, walk index, handshakes
   drc_ctrl #(.MAX_REGIONS(MAX_REGIONS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .status     (status),
      .cmd        (cmd),
      .ram_addr   (ram_addr)
   );

   // store, geometry, areas and result register
   drc_datapath #(.MAX_REGIONS(MAX_REGIONS), .COORD_BITS(COORD_BITS)) u_dp (
      .clock           (clock),
      .cmd             (cmd),
      .ram_addr        (ram_addr),
      .req_rect_x      (req_rect_x),
      .req_rect_y      (req_rect_y),
      .req_rect_w      (req_rect_w),
      .req_rect_h      (req_rect_h),
      .status          (status),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_w       (rsp_out_w),
      .rsp_out_h       (rsp_out_h),
      .rsp_last_rect   (rsp_last_rect),
      .rsp_store_empty (rsp_store_empty)
   );

endmodule
`default_nettype wire

>>> hdl/drc_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module drc_ram #(
   parameter int WIDTH = 50,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

>>> hdl/drc_datapath.sv
// Datapath: rectangle store, cover and containment logic, area multipliers, result register.
`default_nettype none
module drc_datapath #(
   parameter int MAX_REGIONS = 16,
   parameter int COORD_BITS  = 12
) (
   input  wire logic                           clock,
   input  wire drc_pkg::cmd_type               cmd,
   input  wire logic [$clog2(MAX_REGIONS)-1:0] ram_addr,
   input  wire logic [COORD_BITS-1:0]          req_rect_x,
   input  wire logic [COORD_BITS-1:0]          req_rect_y,
   input  wire logic [COORD_BITS:0]            req_rect_w,
   input  wire logic [COORD_BITS:0]            req_rect_h,
   output drc_pkg::status_type                 status,
   output logic      [COORD_BITS-1:0]          rsp_out_x,
   output logic      [COORD_BITS-1:0]          rsp_out_y,
   output logic      [COORD_BITS:0]            rsp_out_w,
   output logic      [COORD_BITS:0]            rsp_out_h,
   output logic                                rsp_last_rect,
   output logic                                rsp_store_empty
);

   localparam int P     = COORD_BITS;
   localparam int S     = COORD_BITS + 1;
   localparam int RW    = 2 * P + 2 * S;
   localparam int AREAW = 2 * S;
   localparam int SUMW  = AREAW + $clog2(MAX_REGIONS) + 1;

   function automatic logic [P-1:0] fx(input logic [RW-1:0] r);
      return r[RW-1 -: P];
   endfunction
   function automatic logic [P-1:0] fy(input logic [RW-1:0] r);
      return r[RW-1-P -: P];
   endfunction
   function automatic logic [S-1:0] fw(input logic [RW-1:0] r);
      return r[2*S-1 -: S];
   endfunction
   function automatic logic [S-1:0] fh(input logic [RW-1:0] r);
      return r[S-1:0];
   endfunction

   // far edges, one bit wider than a size
   function automatic logic [S:0] fr(input logic [RW-1:0] r);
      return {2'b00, fx(r)} + {1'b0, fw(r)};
   endfunction
   function automatic logic [S:0] fb(input logic [RW-1:0] r);
      return {2'b00, fy(r)} + {1'b0, fh(r)};
   endfunction

   function automatic logic holds(input logic [RW-1:0] a, input logic [RW-1:0] b);
      return (fx(a) <= fx(b)) && (fy(a) <= fy(b)) && (fr(a) >= fr(b)) && (fb(a) >= fb(b));
   endfunction

   function automatic logic [RW-1:0] bound_box(input logic [RW-1:0] a,
                                               input logic [RW-1:0] b);
      logic [P-1:0] cx;
      logic [P-1:0] cy;
      logic [S:0]   cr;
      logic [S:0]   cb;
      logic [S:0]   dw;
      logic [S:0]   dh;
      cx = (fx(a) < fx(b)) ? fx(a) : fx(b);
      cy = (fy(a) < fy(b)) ? fy(a) : fy(b);
      cr = (fr(a) > fr(b)) ? fr(a) : fr(b);
      cb = (fb(a) > fb(b)) ? fb(a) : fb(b);
      dw = cr - {2'b00, cx};
      dh = cb - {2'b00, cy};
      if (fw(b) == '0 || fh(b) == '0) begin
         return a;
      end else if (fw(a) == '0 || fh(a) == '0) begin
         return b;
      end
      return {cx, cy, dw[S-1:0], dh[S-1:0]};
   endfunction

   logic [RW-1:0]    s_ff, e_ff, m_ff, m0_ff, run_ff, runn_ff;
   logic [AREAW-1:0] area_s_ff, area_e_ff, area_m_ff, area_run_ff;
   logic [SUMW-1:0]  sum_ff;
   logic [RW-1:0]    ram_wdata;
   logic [RW-1:0]    ram_rdata;
   logic [SUMW-1:0]  sum_in;
   logic [AREAW:0]   pair_sum;

   logic [P-1:0] rsp_x_ff, rsp_y_ff;
   logic [S-1:0] rsp_w_ff, rsp_h_ff;
   logic         rsp_last_ff, rsp_empty_ff;

   drc_ram #(.WIDTH(RW), .DEPTH(MAX_REGIONS)) u_store (
      .clock (clock),
      .we    (cmd.ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_comb begin
      case (cmd.wsel)
         drc_pkg::WSEL_SUBJ:  ram_wdata = s_ff;
         drc_pkg::WSEL_MERGE: ram_wdata = m_ff;
         drc_pkg::WSEL_RUN:   ram_wdata = runn_ff;
         drc_pkg::WSEL_M0:    ram_wdata = m0_ff;
         default:             ram_wdata = s_ff;
      endcase
   end

   assign sum_in   = sum_ff + {{(SUMW-AREAW){1'b0}}, area_e_ff};
   assign pair_sum = {1'b0, area_e_ff} + {1'b0, area_s_ff};

   assign status.entry_holds_subj = holds(e_ff, s_ff);
   assign status.subj_holds_entry = holds(s_ff, e_ff);
   assign status.merge_ok         = {1'b0, area_m_ff} <= pair_sum;
   assign status.run_ok           = {{(SUMW-AREAW){1'b0}}, area_run_ff} <= sum_in;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         s_ff   <= {req_rect_x, req_rect_y, req_rect_w, req_rect_h};
         run_ff <= {req_rect_x, req_rect_y, req_rect_w, req_rect_h};
         sum_ff <= '0;
      end
      if (cmd.load_ram_subj) begin
         s_ff <= ram_rdata;
      end
      if (cmd.calc_sarea) begin
         area_s_ff <= fw(s_ff) * fh(s_ff);
      end
      if (cmd.load_entry) begin
         e_ff    <= ram_rdata;
         m_ff    <= bound_box(ram_rdata, s_ff);
         runn_ff <= bound_box(run_ff, ram_rdata);
      end
      if (cmd.calc_areas) begin
         area_e_ff   <= fw(e_ff) * fh(e_ff);
         area_m_ff   <= fw(m_ff) * fh(m_ff);
         area_run_ff <= fw(runn_ff) * fh(runn_ff);
      end
      if (cmd.run_update) begin
         run_ff <= runn_ff;
         sum_ff <= sum_in;
      end
      if (cmd.save_m0) begin
         m0_ff <= m_ff;
      end
      if (cmd.rsp_load) begin
         rsp_last_ff  <= cmd.rsp_last;
         rsp_empty_ff <= cmd.rsp_empty;
         if (cmd.rsp_empty) begin
            rsp_x_ff <= '0;
            rsp_y_ff <= '0;
            rsp_w_ff <= '0;
            rsp_h_ff <= '0;
         end else begin
            rsp_x_ff <= fx(s_ff);
            rsp_y_ff <= fy(s_ff);
            rsp_w_ff <= fw(s_ff);
            rsp_h_ff <= fh(s_ff);
         end
      end
   end

   assign rsp_out_x       = rsp_x_ff;
   assign rsp_out_y       = rsp_y_ff;
   assign rsp_out_w       = rsp_w_ff;
   assign rsp_out_h       = rsp_h_ff;
   assign rsp_last_rect   = rsp_last_ff;
   assign rsp_store_empty = rsp_empty_ff;

endmodule
`default_nettype wire

>>> hdl/drc_ctrl.sv
// Controller: sequences the add walk and the drain over the rectangle store.
`default_nettype none
module drc_ctrl #(
   parameter int MAX_REGIONS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_action,
   output logic                                req_stall,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   input  wire drc_pkg::status_type            status,
   output drc_pkg::cmd_type                    cmd,
   output logic [$clog2(MAX_REGIONS)-1:0]      ram_addr
);

   localparam int AW = $clog2(MAX_REGIONS);
   localparam int CW = $clog2(MAX_REGIONS + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REGIONS);

   typedef enum logic [3:0] {
      S_IDLE,
      S_POP,
      S_TAKE,
      S_SAREA,
      S_RD,
      S_LD,
      S_MUL,
      S_DEC,
      S_EMIT,
      S_EMPTY
   } state_type;

   state_type   state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in, idx_ff, idx_in;
   logic        drain_ff, drain_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] cnt_dec, idx_nx;
   logic        rsp_free;

   assign cnt_dec   = cnt_ff - 1'b1;
   assign idx_nx    = idx_ff + 1'b1;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      drain_in = drain_ff;
      cmd      = '0;
      cmd.wsel = drc_pkg::WSEL_SUBJ;
      ram_addr = idx_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               drain_in = req_action;
               if (!req_action) begin
                  cmd.load_req = 1'b1;
                  state_in     = S_SAREA;
               end else if (cnt_ff == '0) begin
                  state_in = S_EMPTY;
               end else begin
                  state_in = S_POP;
               end
            end
         end
         S_POP: begin
            ram_addr = cnt_dec[AW-1:0];
            cnt_in   = cnt_dec;
            state_in = S_TAKE;
         end
         S_TAKE: begin
            cmd.load_ram_subj = 1'b1;
            state_in          = S_SAREA;
         end
         S_SAREA: begin
            cmd.calc_sarea = 1'b1;
            idx_in         = '0;
            if (cnt_ff != '0) begin
               state_in = S_RD;
            end else if (drain_ff) begin
               state_in = S_EMIT;
            end else begin
               cmd.ram_we = 1'b1;
               ram_addr   = cnt_ff[AW-1:0];
               cnt_in     = cnt_ff + 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_RD: begin
            state_in = S_LD;
         end
         S_LD: begin
            cmd.load_entry = 1'b1;
            state_in       = S_MUL;
         end
         S_MUL: begin
            cmd.calc_areas = 1'b1;
            state_in       = S_DEC;
         end
         S_DEC: begin
            if (!drain_ff) begin
               state_in = S_IDLE;
               if (status.entry_holds_subj) begin
                  // drop the new rectangle
               end else if (status.subj_holds_entry) begin
                  cmd.ram_we = 1'b1;
                  cmd.wsel   = drc_pkg::WSEL_SUBJ;
               end else if (status.merge_ok) begin
                  cmd.ram_we = 1'b1;
                  cmd.wsel   = drc_pkg::WSEL_MERGE;
               end else if (status.run_ok) begin
                  cmd.ram_we = 1'b1;
                  cmd.wsel   = drc_pkg::WSEL_RUN;
                  ram_addr   = '0;
               end else begin
                  cmd.run_update = 1'b1;
                  cmd.save_m0    = idx_ff == '0;
                  if (idx_nx != cnt_ff) begin
                     idx_in   = idx_nx;
                     state_in = S_RD;
                  end else if (cnt_ff != MAX_CNT) begin
                     cmd.ram_we = 1'b1;
                     cmd.wsel   = drc_pkg::WSEL_SUBJ;
                     ram_addr   = cnt_ff[AW-1:0];
                     cnt_in     = cnt_ff + 1'b1;
                  end else begin
                     cmd.ram_we = 1'b1;
                     cmd.wsel   = drc_pkg::WSEL_M0;
                     ram_addr   = '0;
                  end
               end
            end else begin
               if (status.entry_holds_subj || status.merge_ok) begin
                  cmd.ram_we = !status.entry_holds_subj;
                  cmd.wsel   = drc_pkg::WSEL_MERGE;
                  state_in   = (cnt_ff == '0) ? S_IDLE : S_POP;
               end else if (idx_nx == cnt_ff) begin
                  state_in = S_EMIT;
               end else begin
                  idx_in   = idx_nx;
                  state_in = S_RD;
               end
            end
         end
         S_EMIT: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_last = cnt_ff == '0;
               state_in     = (cnt_ff == '0) ? S_IDLE : S_POP;
            end
         end
         S_EMPTY: begin
            if (rsp_free) begin
               cmd.rsp_load  = 1'b1;
               cmd.rsp_last  = 1'b1;
               cmd.rsp_empty = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         drain_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire
